@@ hdl/dcfe_pkg.sv @@
// shared types, constants and the colour mapping for the debug channel frame encoder
package dcfe_pkg;

    // one accepted byte causes at most this many words
    localparam int WORDS_MAX = 3;

    // word tags
    localparam logic [15:0] START_TAG = 16'hFEC1;
    localparam logic [7:0]  END_TAG   = 8'hF0;
    localparam logic [7:0]  CHAR_TAG  = 8'h54;

    // characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_G  = 8'h67;
    localparam logic [7:0] CH_W  = 8'h77;
    localparam logic [7:0] CH_R  = 8'h72;

    // stream numbers with a fixed colour
    localparam logic [7:0] SID_G = 8'd0;
    localparam logic [7:0] SID_W = 8'd1;
    localparam logic [7:0] SID_R = 8'd2;

    // words caused by one beat, in output order
    typedef struct packed {
        logic [1:0]                     cnt;
        logic [WORDS_MAX-1:0][31:0]     words;
    } t_rec;

    function automatic logic [7:0] color_of(input logic [7:0] sid);
        logic [7:0] c;
        case (sid)
            SID_G:   c = CH_G;
            SID_W:   c = CH_W;
            SID_R:   c = CH_R;
            default: c = sid;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/dcfe_front.sv @@
// front end: takes message bytes, tracks chunk state and builds the words of each beat
module dcfe_front
    import dcfe_pkg::*;
#(
    parameter int FRAME_BYTES = 128,
    parameter int LEN_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic [7:0]          i_stream_id,
    input  logic [LEN_BITS-1:0] i_msg_len,
    output logic                o_push,
    output t_rec                o_rec
);

    localparam logic [7:0]          FB8  = 8'(FRAME_BYTES);
    localparam logic [LEN_BITS-1:0] FBL  = LEN_BITS'(FRAME_BYTES);

    logic [LEN_BITS-1:0] r_msg_pos, n_msg_pos;
    logic [7:0]          r_chunk_pos, n_chunk_pos;
    logic [7:0]          r_chunk_len, n_chunk_len;
    logic [23:0]         r_acc, n_acc;
    logic [7:0]          r_sum, n_sum;

    logic [7:0]          color;
    logic                len_zero;
    logic                single;
    logic                open;
    logic [LEN_BITS-1:0] rem;
    logic [7:0]          clen;
    logic [7:0]          clen_eff;
    logic [7:0]          sum_new;
    logic [1:0]          k;
    logic [7:0]          cpos_inc;
    logic                done;
    logic                flush;
    logic [31:0]         data_word;
    logic [LEN_BITS-1:0] mpos_inc;
    logic                msg_end;
    logic [31:0]         char_base;
    t_rec                rec;

    // classification of the incoming byte
    always_comb begin
        color     = color_of(i_stream_id);
        len_zero  = (i_msg_len == '0);
        single    = (r_msg_pos == '0) && (i_msg_len == LEN_BITS'(1));
        open      = (r_chunk_pos == 8'd0);
        rem       = (i_msg_len > r_msg_pos) ? (i_msg_len - r_msg_pos) : LEN_BITS'(1);
        clen      = (rem > FBL) ? FB8 : rem[7:0];
        clen_eff  = open ? clen : r_chunk_len;
        sum_new   = (open ? clen : r_sum) + i_data_byte;
        k         = r_chunk_pos[1:0];
        cpos_inc  = r_chunk_pos + 8'd1;
        done      = (cpos_inc >= clen_eff);
        flush     = (k == 2'd3) || done;
        mpos_inc  = r_msg_pos + LEN_BITS'(1);
        msg_end   = (mpos_inc >= i_msg_len) || (mpos_inc == '0);
        char_base = {CHAR_TAG, 8'h00, color, 8'h00};
    end

    // left-align the data word by the byte slot it ends in
    always_comb begin
        case (k)
            2'd0:    data_word = {i_data_byte, 24'h0};
            2'd1:    data_word = {(open ? 8'h00 : r_acc[7:0]), i_data_byte, 16'h0};
            2'd2:    data_word = {(open ? 16'h0 : r_acc[15:0]), i_data_byte, 8'h0};
            default: data_word = {(open ? 24'h0 : r_acc), i_data_byte};
        endcase
    end

    // pack the words of this beat in order
    always_comb begin
        rec = '0;
        if (len_zero) begin
            rec.cnt = 2'd0;
        end else if (single) begin
            if (i_data_byte == CH_LF) begin
                rec.words[0] = char_base | {24'h0, CH_CR};
                rec.words[1] = char_base | {24'h0, CH_LF};
                rec.cnt      = 2'd2;
            end else begin
                rec.words[0] = char_base | {24'h0, i_data_byte};
                rec.cnt      = 2'd1;
            end
        end else begin
            if (open) begin
                rec.words[rec.cnt] = {START_TAG, color, clen};
                rec.cnt            = rec.cnt + 2'd1;
            end
            if (flush) begin
                rec.words[rec.cnt] = data_word;
                rec.cnt            = rec.cnt + 2'd1;
            end
            if (done) begin
                rec.words[rec.cnt] = {END_TAG, sum_new, 16'h0};
                rec.cnt            = rec.cnt + 2'd1;
            end
        end
    end

    // next chunk state
    always_comb begin
        n_msg_pos   = r_msg_pos;
        n_chunk_pos = r_chunk_pos;
        n_chunk_len = r_chunk_len;
        n_acc       = r_acc;
        n_sum       = r_sum;
        if (i_accept && !len_zero && !single) begin
            n_chunk_len = clen_eff;
            n_sum       = done ? 8'd0 : sum_new;
            n_acc       = flush ? 24'h0 : {(open ? 16'h0 : r_acc[15:0]), i_data_byte};
            n_chunk_pos = done ? 8'd0 : cpos_inc;
            n_msg_pos   = mpos_inc;
            if (msg_end) begin
                n_msg_pos   = '0;
                n_chunk_pos = 8'd0;
                n_acc       = 24'h0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_pos   <= '0;
            r_chunk_pos <= 8'd0;
            r_chunk_len <= 8'd0;
            r_acc       <= 24'h0;
            r_sum       <= 8'd0;
        end else begin
            r_msg_pos   <= n_msg_pos;
            r_chunk_pos <= n_chunk_pos;
            r_chunk_len <= n_chunk_len;
            r_acc       <= n_acc;
            r_sum       <= n_sum;
        end
    end

    assign o_push = i_accept && (rec.cnt != 2'd0);
    assign o_rec  = rec;

endmodule

@@ hdl/dcfe_queue.sv @@
// short queue of word groups between front and back end
module dcfe_queue
    import dcfe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hdl/dcfe_back.sv @@
// back end: sends the queued words one beat at a time through an output register
module dcfe_back
    import dcfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_rec        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_word,
    output logic        o_last
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [31:0] r_word;
    logic        r_last;
    logic        load;
    logic        is_last;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign is_last = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop   = load && is_last;

    // word index within the head group and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_head.words[r_idx];
            r_last <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

@@ hdl/debug_channel_frame_encoder_unit.sv @@
// Debug channel frame encoder: turns message bytes into start, data, end and character words
// A beat's words go through the group queue, then the back end's output register.
// Throughput: one byte per cycle in; one word per cycle out of the back end when not stalled.
// A byte causes zero to three words; the front stalls only while the group queue is full.
// Reset (i_rst_n low, synchronous) clears chunk state, queue pointers and output valid.
module debug_channel_frame_encoder_unit
    import dcfe_pkg::*;
#(
    parameter int FRAME_BYTES = 128,
    parameter int LEN_BITS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic [7:0]          i_stream_id,
    input  logic [LEN_BITS-1:0] i_msg_len,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [31:0]         o_dcc_word,
    output logic                o_last_word
);

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    t_rec rec;
    t_rec head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // front end
    dcfe_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .LEN_BITS    (LEN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_stream_id (i_stream_id),
        .i_msg_len   (i_msg_len),
        .o_push      (push),
        .o_rec       (rec)
    );

    // word group queue
    dcfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // back end
    dcfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_dcc_word),
        .o_last  (o_last_word)
    );

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the debug channel frame encoder unit
module tb_top;
    import dcfe_pkg::*;

    localparam int FRAME_LEN     = 128;
    localparam int LEN_W         = 16;
    localparam int RANDOM_BYTES  = 370;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTY} t_stall_mode;
    typedef enum {GAPS_NONE, GAPS_BURSTS} t_gap_mode;

    // one expected output beat
    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_dcc_beat;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [7:0]         i_data_byte  = 8'h00;
    logic [7:0]         i_stream_id  = 8'h00;
    logic [LEN_W-1:0]   i_msg_len    = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [31:0]        o_dcc_word;
    logic               o_last_word;

    debug_channel_frame_encoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_stream_id (i_stream_id),
        .i_msg_len   (i_msg_len),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dcc_word  (o_dcc_word),
        .o_last_word (o_last_word)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // encoder state as the predictor sees it
    logic [LEN_W-1:0] msg_pos;
    logic [7:0]       chunk_pos;
    logic [7:0]       chunk_len;
    logic [23:0]      word_acc;
    logic [7:0]       chunk_sum;

    t_dcc_beat   dcc_expected[$];
    t_stall_mode stall_mode = STALL_NONE;
    t_gap_mode   gap_mode   = GAPS_NONE;
    int          burst_left = 0;
    int          n_errors   = 0;
    int          n_bytes    = 0;
    int          n_ignored  = 0;
    int          n_words    = 0;
    int          n_chunks   = 0;
    int          n_chars    = 0;

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("MISMATCH %s: expected %h got %h", what, exp_val, got_val);
        n_errors++;
    endtask

    function automatic logic [7:0] stream_colour(input logic [7:0] sid);
        if (sid == SID_G) return CH_G;
        if (sid == SID_W) return CH_W;
        if (sid == SID_R) return CH_R;
        return sid;
    endfunction

    // work out the words caused by one accepted byte and queue them
    function automatic void predict_words(input logic [7:0] b, input logic [7:0] sid,
                                          input logic [LEN_W-1:0] len);
        logic [31:0]      words[$];
        logic [7:0]       col;
        logic [LEN_W-1:0] rem;
        logic [1:0]       k;
        logic             chunk_done;
        t_dcc_beat        beat;
        col = stream_colour(sid);
        // zero length bytes are dropped without touching the state
        if (len == 0) begin
            n_ignored++;
            return;
        end
        if (msg_pos == 0 && len == 1) begin
            // single character; a newline goes out as cr then lf
            if (b == CH_LF) begin
                words.push_back({CHAR_TAG, 8'h00, col, CH_CR});
                words.push_back({CHAR_TAG, 8'h00, col, CH_LF});
            end else begin
                words.push_back({CHAR_TAG, 8'h00, col, b});
            end
            n_chars++;
        end else begin
            // chunk opens on this byte
            if (chunk_pos == 0) begin
                rem       = (len > msg_pos) ? len - msg_pos : LEN_W'(1);
                chunk_len = (rem > FRAME_LEN) ? 8'(FRAME_LEN) : rem[7:0];
                chunk_sum = chunk_len;
                word_acc  = '0;
                words.push_back({START_TAG, col, chunk_len});
                n_chunks++;
            end
            chunk_sum  = chunk_sum + b;
            k          = chunk_pos[1:0];
            chunk_pos  = chunk_pos + 8'd1;
            chunk_done = (chunk_pos >= chunk_len);
            // full word, or left-aligned tail of the chunk
            if (k == 2'd3 || chunk_done) begin
                words.push_back({word_acc, b} << (8 * (3 - k)));
                word_acc = '0;
            end else begin
                word_acc = {word_acc[15:0], b};
            end
            if (chunk_done) begin
                words.push_back({END_TAG, chunk_sum, 16'h0000});
                chunk_pos = '0;
                chunk_sum = '0;
            end
            msg_pos = msg_pos + LEN_W'(1);
            if (msg_pos >= len || msg_pos == 0) begin
                msg_pos   = '0;
                chunk_pos = '0;
                word_acc  = '0;
            end
        end
        foreach (words[i]) begin
            beat.word = words[i];
            beat.last = (i == words.size() - 1);
            dcc_expected.push_back(beat);
        end
    endfunction

    // one input beat, with burst gaps ahead of it when enabled
    task automatic send_byte(input logic [7:0] b, input logic [7:0] sid,
                             input logic [LEN_W-1:0] len);
        int gap;
        if (gap_mode == GAPS_BURSTS && burst_left <= 0) begin
            gap = $urandom_range(8, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(16, 1);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_stream_id <= sid;
        i_msg_len   <= len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_words(b, sid, len);
        n_bytes++;
        burst_left--;
    endtask

    function automatic logic [7:0] pick_stream();
        if ($urandom_range(99, 0) < 70) return 8'($urandom_range(3, 0));
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99, 0) < 15) return CH_LF;
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic pick_modes();
        stall_mode = t_stall_mode'($urandom_range(2, 0));
        gap_mode   = t_gap_mode'($urandom_range(1, 0));
    endtask

    // result side: stall pattern and comparison with the oldest expectation
    int stall_run = 0;
    always @(posedge i_clk) begin
        t_dcc_beat exp_beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_words++;
            if (dcc_expected.size() == 0) begin
                report_mismatch("unexpected word", 32'h0, o_dcc_word);
            end else begin
                exp_beat = dcc_expected.pop_front();
                if (o_dcc_word !== exp_beat.word)
                    report_mismatch("dcc_word", exp_beat.word, o_dcc_word);
                if (o_last_word !== exp_beat.last)
                    report_mismatch("last_word", 32'(exp_beat.last), 32'(o_last_word));
            end
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(99, 0) < 35);
            end
            default: begin
                if (stall_run <= 0) begin
                    stall_run = $urandom_range(12, 1);
                    i_out_stall <= ~i_out_stall;
                end
                stall_run--;
            end
        endcase
    end

    // watchdog on cycles with no beat moving on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // single-byte messages, newline expansion, colours and raw stream ids
    task automatic test_single_chars();
        send_byte(8'h41, SID_G, 1);
        send_byte(CH_LF, SID_W, 1);
        send_byte(8'h00, SID_R, 1);
        send_byte(8'hFF, 8'hFF, 1);
        send_byte(CH_LF, 8'h03, 1);
    endtask

    // zero length bytes are dropped, on their own and inside a message
    task automatic test_zero_length();
        send_byte(8'h5A, SID_G, 0);
        send_byte(8'h11, SID_W, 3);
        send_byte(8'hEE, SID_R, 0);
        send_byte(8'h22, SID_R, 3);
        send_byte(8'h33, 8'h40, 3);
    endtask

    // short frames: partial tail, exact word, word plus one byte
    task automatic test_short_messages();
        send_byte(8'hFF, 8'h55, 2);
        send_byte(8'h00, 8'h55, 2);
        send_byte(CH_LF, SID_G, 4);
        send_byte(8'h80, SID_W, 4);
        send_byte(8'h7F, SID_R, 4);
        send_byte(8'h01, SID_G, 4);
        for (int i = 1; i <= 5; i++) send_byte(8'(i), SID_R, 5);
    endtask

    // length shrinks below the position mid-message
    task automatic test_length_change();
        send_byte(8'hA1, SID_G, 16'hFFFF);
        send_byte(8'hA2, SID_G, 16'hFFFF);
        send_byte(8'hA3, SID_G, 16'hFFFF);
        send_byte(8'hA4, SID_W, 16'h0001);
        send_byte(8'hB1, 8'hC0, 2);
        send_byte(8'hB2, 8'hC0, 1);
    endtask

    // one message across two chunks, then a cut at a chunk boundary
    task automatic test_chunk_boundaries();
        int               msg_bytes;
        logic [LEN_W-1:0] len;
        msg_bytes = $urandom_range(140, 129);
        for (int i = 0; i < msg_bytes; i++)
            send_byte(pick_byte(), pick_stream(), LEN_W'(msg_bytes));
        len = 16'h8000 | 16'($urandom_range(65535, 0));
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(pick_byte(), pick_stream(), len);
        send_byte(pick_byte(), pick_stream(), LEN_W'($urandom_range(FRAME_LEN, 1)));
    endtask

    // random mix of well-formed messages, broken ones and dropped bytes
    task automatic test_random_messages(input int target);
        int               start_bytes;
        int               msg_bytes;
        int               sel;
        logic [LEN_W-1:0] len;
        start_bytes = n_bytes - n_ignored;
        while (n_bytes - n_ignored - start_bytes < target) begin
            if ($urandom_range(9, 0) == 0) pick_modes();
            sel = $urandom_range(99, 0);
            if (sel < 40) begin
                send_byte(pick_byte(), pick_stream(), 1);
            end else if (sel < 80) begin
                msg_bytes = $urandom_range(12, 2);
                for (int i = 0; i < msg_bytes; i++)
                    send_byte(pick_byte(), pick_stream(), LEN_W'(msg_bytes));
            end else if (sel < 90) begin
                // long length that is cut short by a smaller one
                msg_bytes = $urandom_range(6, 1);
                len = LEN_W'($urandom_range(65535, msg_bytes + 1));
                for (int i = 0; i < msg_bytes; i++)
                    send_byte(pick_byte(), pick_stream(), len);
                send_byte(pick_byte(), pick_stream(),
                          LEN_W'($urandom_range(msg_bytes, 1)));
            end else begin
                send_byte(pick_byte(), pick_stream(), 0);
            end
        end
    endtask

    // stimulus sequence
    initial begin
        msg_pos   = '0;
        chunk_pos = '0;
        chunk_len = '0;
        word_acc  = '0;
        chunk_sum = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_chars();
        stall_mode = STALL_RANDOM;
        test_zero_length();
        gap_mode = GAPS_BURSTS;
        test_short_messages();
        stall_mode = STALL_BURSTY;
        test_length_change();
        pick_modes();
        test_chunk_boundaries();
        test_random_messages(RANDOM_BYTES - (n_bytes - n_ignored));
        i_in_valid <= 1'b0;

        // drain, then watch for stray words
        while (dcc_expected.size() != 0) @(posedge i_clk);
        stall_mode = STALL_NONE;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dcc_expected.size() != 0)
            report_mismatch("words never delivered", 32'(dcc_expected.size()), 32'h0);

        $display("sent %0d bytes (%0d dropped with zero length), checked %0d words",
                 n_bytes, n_ignored, n_words);
        $display("covered %0d single characters and %0d chunk starts", n_chars, n_chunks);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
